// File: hdl/tcci_pkg.sv
// Shared types and constants for the tick clock with cycle interpolation.
package tcci_pkg;

  localparam int unsigned WholeW  = 10;
  localparam int unsigned FractW  = 31;
  localparam int unsigned CountW  = 64;
  localparam int unsigned FracAccW = 32;
  localparam int unsigned StepW   = 6;

  localparam logic [WholeW-1:0]   WholeRst   = 10'd500;
  localparam logic [FractW-1:0]   FractRst   = '0;
  localparam logic [FracAccW-1:0] FractOneMs = 32'h8000_0000;
  localparam logic [StepW-1:0]    LastStep   = 6'd63;

  localparam int unsigned AddrW  = 3;
  localparam logic        RegIdxWhole = 1'b0;
  localparam logic        RegIdxFract = 1'b1;

  localparam logic        ReqTick  = 1'b0;
  localparam logic        ReqQuery = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StDiv,
    StFin
  } tcci_state_e;

endpackage

// File: hdl/tick_clock_with_cycle_interpolation_core.sv
// Top level: millisecond clock advanced by ticks, interpolated on query.
//
// Input stream: s_axis_tuser selects the request (0 = tick, 1 = query),
// s_axis_tdata carries the cycle counter value sampled at the event.
// Output stream: one transaction per input, tdata = {tick_total, timestamp_ms}.
// Configuration: APB port, register 0 (addr 0) whole ms per tick,
// register 1 (addr 4) fraction per tick in 2^-31 ms units; pready is always high.
//
// A tick updates the clock state in the cycle it is accepted; its result is
// valid on the next cycle. A query result passes through these steps: the cycle
// delta is formed at acceptance, then StMul forms the delta * whole-ms product,
// StDiv runs the restoring divider (one quotient bit per cycle, the shared
// subtractor), and StFin does the final add. With an unknown rate the divider is skipped.
// The block takes one transaction at a time: s_axis_tready is low while a
// request is in work or a result waits in the output register. A stalled
// output simply holds its data until m_axis_tready is seen.
// Reset (rst_ni low, asynchronous) clears the clock state and restores the
// register defaults (500 ms whole, zero fraction).
module tick_clock_with_cycle_interpolation_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // slave stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [63:0]                  s_axis_tdata,  // [63:0] cycle_count
  input  logic                         s_axis_tuser,  // [0] req_type
  // master stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [127:0]                 m_axis_tdata,  // [63:0] timestamp_ms, [127:64] tick_total
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tcci_pkg::AddrW-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import tcci_pkg::*;

  tcci_state_e state_q, state_d;

  logic [WholeW-1:0]   whole_reg_q;
  logic [FractW-1:0]   fract_reg_q;

  logic [CountW-1:0]   last_q, cpt_q, whole_ms_q, ticks_q;
  logic [FracAccW-1:0] frac_q;

  logic [CountW-1:0]   opnd_q;   // delta, then product, then quotient
  logic [CountW-1:0]   rem_q;
  logic [StepW-1:0]    step_q;

  logic                out_valid_q;
  logic [CountW-1:0]   out_ts_q, out_ticks_q;

  logic                in_acc, out_acc, cfg_wr;
  logic [FracAccW-1:0] frac_sum;
  logic                frac_carry;
  logic [CountW:0]     div_shift, div_diff;
  logic                div_bit;
  logic [CountW+WholeW-1:0] prod_full;

  // APB
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_comb begin
    case (paddr[2])
      RegIdxWhole: prdata = {{(32-WholeW){1'b0}}, whole_reg_q};
      RegIdxFract: prdata = {{(32-FractW){1'b0}}, fract_reg_q};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      whole_reg_q <= WholeRst;
      fract_reg_q <= FractRst;
    end else if (cfg_wr) begin
      if (paddr[2] == RegIdxWhole) whole_reg_q <= pwdata[WholeW-1:0];
      else                         fract_reg_q <= pwdata[FractW-1:0];
    end
  end

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Tick arithmetic; fraction stays at or below 2^31 so the sum cannot overflow
  assign frac_sum   = frac_q + {1'b0, fract_reg_q};
  assign frac_carry = frac_sum > FractOneMs;

  // Divider step: shift in the next dividend bit, trial subtract
  assign div_shift = {rem_q, opnd_q[CountW-1]};
  assign div_diff  = div_shift - {1'b0, cpt_q};
  assign div_bit   = !div_diff[CountW];

  assign prod_full = opnd_q * whole_reg_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (in_acc && s_axis_tuser == ReqQuery) state_d = StMul;
      StMul:  state_d = (cpt_q == '0) ? StFin : StDiv;
      StDiv:  if (step_q == LastStep) state_d = StFin;
      StFin:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Outputs
  always_comb begin
    s_axis_tready = (state_q == StIdle) && !out_valid_q;
    m_axis_tvalid = out_valid_q;
    m_axis_tdata  = {out_ticks_q, out_ts_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      last_q      <= '0;
      cpt_q       <= '0;
      whole_ms_q  <= '0;
      frac_q      <= '0;
      ticks_q     <= '0;
      step_q      <= '0;
    end else begin
      state_q <= state_d;
      if (out_acc) out_valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (in_acc && s_axis_tuser == ReqTick) begin
            if (last_q != '0) cpt_q <= s_axis_tdata - last_q;
            last_q     <= s_axis_tdata;
            ticks_q    <= ticks_q + 64'd1;
            whole_ms_q <= whole_ms_q + {{(CountW-WholeW){1'b0}}, whole_reg_q}
                          + {{(CountW-1){1'b0}}, frac_carry};
            frac_q     <= frac_carry ? frac_sum - FractOneMs : frac_sum;
            out_valid_q <= 1'b1;
          end
          step_q <= '0;
        end
        StDiv:  step_q <= step_q + 6'd1;
        StFin:  out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        opnd_q <= s_axis_tdata - last_q;
        rem_q  <= '0;
        if (in_acc && s_axis_tuser == ReqTick) begin
          out_ts_q    <= whole_ms_q + {{(CountW-WholeW){1'b0}}, whole_reg_q}
                         + {{(CountW-1){1'b0}}, frac_carry};
          out_ticks_q <= ticks_q + 64'd1;
        end
      end
      StMul: begin
        // unknown rate: interpolation term is zero
        opnd_q <= (cpt_q == '0) ? '0 : prod_full[CountW-1:0];
      end
      StDiv: begin
        rem_q  <= div_bit ? div_diff[CountW-1:0] : div_shift[CountW-1:0];
        opnd_q <= {opnd_q[CountW-2:0], div_bit};
      end
      StFin: begin
        out_ts_q    <= whole_ms_q + opnd_q;
        out_ticks_q <= ticks_q;
      end
      default: ;
    endcase
  end

endmodule

// File: hdl/tcci_chk.sv
// Port-level checker for the tick clock core, bound to the top level.
module tcci_chk (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata
);
  import tcci_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output transaction changed");

  a_no_take_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while a result is pending");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready again right after a transaction");

  a_tick_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == ReqTick |=> m_axis_tvalid)
    else $error("tick result not valid on the next cycle");

endmodule

bind tick_clock_with_cycle_interpolation_core tcci_chk u_tcci_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: tb/tb_tick_clock_with_cycle_interpolation_core.sv
// Self-checking testbench for the tick clock with cycle-count interpolation.
module tb_tick_clock_with_cycle_interpolation_core;
  timeunit 1ns;
  timeprecision 1ps;

  import tcci_pkg::*;

  localparam int unsigned CycleLimit   = 400_000;
  localparam int unsigned PhaseItems   = 150;
  localparam int unsigned DrainCycles  = 80;
  localparam int unsigned IdlePercent  = 32;

  typedef struct {
    logic        kind;
    logic [63:0] count;
  } clock_request_t;

  typedef struct {
    logic [63:0] stamp;
    logic [63:0] ticks;
  } clock_reading_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata = '0;   // [63:0] cycle_count
  logic         s_axis_tuser = 1'b0; // [0] req_type
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;        // [63:0] timestamp_ms, [127:64] tick_total
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  // Predicted clock state and register copies
  logic [WholeW-1:0]   cfg_whole = WholeRst;
  logic [FractW-1:0]   cfg_fract = FractRst;
  logic [63:0]         last_tick_count = '0;
  logic [63:0]         tick_period = '0;
  logic [63:0]         clock_ms = '0;
  logic [FracAccW-1:0] clock_frac = '0;
  logic [63:0]         tick_counter = '0;

  clock_request_t pending_requests[$];
  clock_reading_t expected_readings[$];

  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned requests_queued = 0;
  int unsigned readings_seen = 0;
  int unsigned ticks_sent = 0;
  int unsigned queries_sent = 0;
  int unsigned settings_used = 1;
  logic        in_taken = 1'b0;
  logic        calm = 1'b0;

  tick_clock_with_cycle_interpolation_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic flag_error(input string msg);
    $display("MISMATCH @%0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Advance the predicted clock by one accepted transaction and store the reading it yields.
  task automatic advance_clock(input logic kind, input logic [63:0] count);
    clock_reading_t rd;
    logic [63:0] scaled;
    if (kind == ReqTick) begin
      if (last_tick_count != '0) tick_period = count - last_tick_count;
      last_tick_count = count;
      tick_counter = tick_counter + 64'd1;
      clock_ms = clock_ms + {{(64-WholeW){1'b0}}, cfg_whole};
      clock_frac = clock_frac + {1'b0, cfg_fract};
      // carry only when strictly above one millisecond
      if (clock_frac > FractOneMs) begin
        clock_ms = clock_ms + 64'd1;
        clock_frac = clock_frac - FractOneMs;
      end
      rd.stamp = clock_ms;
    end else begin
      scaled = (count - last_tick_count) * {{(64-WholeW){1'b0}}, cfg_whole};
      rd.stamp = clock_ms + ((tick_period != '0) ? scaled / tick_period : 64'd0);
    end
    rd.ticks = tick_counter;
    expected_readings.push_back(rd);
  endtask

  // Input driver: hold each transaction until taken, idle at random between them.
  always @(negedge clk_i) begin
    clock_request_t nxt;
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (pending_requests.size() != 0 &&
          (calm || $urandom_range(0, 99) >= IdlePercent)) begin
        nxt = pending_requests.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= nxt.kind;
        s_axis_tdata  <= nxt.count;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output back-pressure
  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= IdlePercent);
  end

  // Monitor: check results first, then predict from the accepted input.
  always @(posedge clk_i) begin
    clock_reading_t want;
    cycle_count <= cycle_count + 1;
    in_taken <= s_axis_tvalid && s_axis_tready;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      readings_seen++;
      if (expected_readings.size() == 0) begin
        flag_error($sformatf("unexpected result ts=%h ticks=%h",
                             m_axis_tdata[63:0], m_axis_tdata[127:64]));
      end else begin
        want = expected_readings.pop_front();
        if (m_axis_tdata[63:0] !== want.stamp)
          flag_error($sformatf("timestamp_ms got %h want %h", m_axis_tdata[63:0], want.stamp));
        if (m_axis_tdata[127:64] !== want.ticks)
          flag_error($sformatf("tick_total got %h want %h", m_axis_tdata[127:64], want.ticks));
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      if (s_axis_tuser == ReqTick) ticks_sent++;
      else queries_sent++;
      advance_clock(s_axis_tuser, s_axis_tdata);
    end
  end

  task automatic queue_request(input logic kind, input logic [63:0] count);
    clock_request_t req;
    req.kind = kind;
    req.count = count;
    pending_requests.push_back(req);
    requests_queued++;
  endtask

  // Pause the sender until every expected result has come back.
  task automatic drain();
    while (readings_seen != requests_queued) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == RegIdxWhole) cfg_whole = value[WholeW-1:0];
    else cfg_fract = value[FractW-1:0];
  endtask

  task automatic set_rate(input logic [31:0] whole, input logic [31:0] fract);
    write_reg(RegIdxWhole, whole);
    write_reg(RegIdxFract, fract);
    settings_used++;
  endtask

  // Mostly a steady tick train with queries in between; the rest is noise.
  task automatic queue_phase(input int unsigned n);
    logic [63:0] tick_at;
    logic [63:0] span;
    int unsigned r;
    tick_at = rand64();
    span = ($urandom_range(0, 3) == 0) ? {32'd0, $urandom} : 64'($urandom_range(1, 5000));
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 22) begin
        tick_at = tick_at + span + 64'($urandom_range(0, 6)) - 64'd3;
        queue_request(ReqTick, tick_at);
      end else if (r < 88) begin
        queue_request(ReqQuery, tick_at + rand64() % (span + span / 64'd4 + 64'd1));
      end else begin
        case ($urandom_range(0, 3))
          0: queue_request(1'($urandom_range(0, 1)), rand64());
          1: queue_request(ReqTick, 64'd0);
          2: queue_request(ReqTick, tick_at);
          default: queue_request(ReqQuery, tick_at - 64'($urandom_range(1, 100)));
        endcase
      end
    end
  endtask

  initial begin
    while (cycle_count < CycleLimit) @(posedge clk_i);
    $display("timeout after %0d cycles", cycle_count);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset rate: query with nothing known, a zero-count tick, equal and wrapping counts
    queue_request(ReqQuery, 64'd0);
    queue_request(ReqQuery, '1);
    queue_request(ReqTick, 64'd0);
    queue_request(ReqTick, 64'd1000);
    queue_request(ReqQuery, 64'd1500);
    queue_request(ReqTick, 64'd3000);
    queue_request(ReqQuery, 64'd4000);
    queue_request(ReqQuery, 64'd3000);
    queue_request(ReqQuery, 64'd2999);
    queue_request(ReqTick, 64'd3000);
    queue_request(ReqQuery, 64'd3500);
    queue_request(ReqTick, 64'd1000);
    queue_request(ReqQuery, '1);
    queue_request(ReqTick, '1);
    queue_request(ReqTick, 64'd5);
    queue_request(ReqQuery, 64'd6);
    drain();

    // Fraction reaches exactly one millisecond without carry, then carries
    set_rate(32'd1023, 32'h4000_0000);
    queue_request(ReqTick, 64'd100);
    queue_request(ReqTick, 64'd200);
    queue_request(ReqTick, 64'd300);
    queue_request(ReqQuery, 64'd350);
    drain();

    set_rate(32'd0, 32'h7FFF_FFFF);
    queue_request(ReqTick, 64'd400);
    queue_request(ReqTick, 64'd500);
    queue_request(ReqQuery, 64'd450);
    drain();

    for (int unsigned ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_rate(32'd1000, 32'd0);
        1: set_rate(($urandom & ~32'h3FF) | $urandom_range(0, 1023), $urandom);
        2: set_rate(32'd1, 32'h7FFF_FFFF);
        3: set_rate(32'd0, $urandom & 32'h7FFF_FFFF);
        4: set_rate(32'd1023, 32'h7FFF_FFFF);
        default: set_rate($urandom_range(0, 1023), $urandom);
      endcase
      calm = (ph == 2);
      queue_phase(PhaseItems);
      drain();
      calm = 1'b0;
    end

    repeat (DrainCycles) @(negedge clk_i);
    while (expected_readings.size() != 0) begin
      void'(expected_readings.pop_front());
      flag_error("expected result never arrived");
    end

    $display("Covered %0d ticks and %0d queries under %0d rate settings; %0d results checked.",
             ticks_sent, queries_sent, settings_used, readings_seen);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", error_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/tcci_pkg.sv
hdl/tick_clock_with_cycle_interpolation_core.sv
hdl/tcci_chk.sv
tb/tb_tick_clock_with_cycle_interpolation_core.sv
